>>> hdl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and the glyph function for the integer to text unit.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int VALUE_BITS = 32;
   localparam int RADIX_BITS = 6;
   localparam int CHAR_BITS  = 7;
   localparam int ADDR_BITS  = $clog2(VALUE_BITS);
   localparam int COUNT_BITS = $clog2(VALUE_BITS + 1);

   localparam logic [RADIX_BITS-1:0] MIN_RADIX      = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] MAX_RADIX      = RADIX_BITS'(36);
   localparam logic [RADIX_BITS-1:0] DECIMAL_DIGITS = RADIX_BITS'(10);
   localparam logic [CHAR_BITS-1:0]  MINUS_CODE     = CHAR_BITS'(7'h2D);
   localparam logic [CHAR_BITS-1:0]  ZERO_CODE      = CHAR_BITS'(7'h30);
   localparam logic [CHAR_BITS-1:0]  LOWER_A_CODE   = CHAR_BITS'(7'h61);
   localparam logic [CHAR_BITS-1:0]  LOWER_Z_CODE   = CHAR_BITS'(7'h7A);

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [RADIX_BITS-1:0]        radix;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 last;
   } rsp_payload_type;

   typedef struct packed {
      logic                  start;
      logic [RADIX_BITS-1:0] radix;
   } div_ctl_type;

   // digit value to ascii, letters from ten upwards
   function automatic logic [CHAR_BITS-1:0] glyph_of(input logic [RADIX_BITS-1:0] d);
      logic [CHAR_BITS-1:0] code;
      if (d < DECIMAL_DIGITS) begin
         code = ZERO_CODE + CHAR_BITS'(d);
      end else if (d < MAX_RADIX) begin
         code = LOWER_A_CODE + CHAR_BITS'(d - DECIMAL_DIGITS);
      end else begin
         code = LOWER_Z_CODE;
      end
      return code;
   endfunction

endpackage

>>> hdl/itoa_divider.sv
// ----------------------------------------------------------------------------
// itoa_divider
// Iterative restoring divider: value by radix, eight quotient bits a cycle.
// ----------------------------------------------------------------------------
module itoa_divider
   import itoa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctl_type           ctl,
   input  logic [VALUE_BITS-1:0] dividend,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [RADIX_BITS-1:0] remainder
);

   localparam int STEP_BITS = 8;
   localparam int STEPS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS  = STEPS * STEP_BITS;
   localparam int CNT_BITS  = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [PAD_BITS-1:0]   work_ff, work_in;
   logic [RADIX_BITS-1:0] rem_ff, rem_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;

   logic [PAD_BITS-1:0]   work_step;
   logic [RADIX_BITS-1:0] rem_step;

   // one step: eight shift and subtract passes on a six-bit partial remainder
   always_comb begin
      logic [RADIX_BITS:0]   trial;
      logic [PAD_BITS-1:0]   w;
      logic [RADIX_BITS-1:0] r;
      w = work_ff;
      r = rem_ff;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial = {r, w[PAD_BITS-1]};
         w     = {w[PAD_BITS-2:0], 1'b0};
         if (trial >= {1'b0, radix_ff}) begin
            trial = trial - {1'b0, radix_ff};
            w[0]  = 1'b1;
         end
         r = trial[RADIX_BITS-1:0];
      end
      work_step = w;
      rem_step  = r;
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         work_in  = PAD_BITS'(dividend);
         rem_in   = '0;
         radix_in = ctl.radix;
      end else if (busy_ff) begin
         work_in = work_step;
         rem_in  = rem_step;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   assign done      = done_ff;
   assign quotient  = work_ff[VALUE_BITS-1:0];
   assign remainder = rem_ff;

endmodule

>>> hdl/itoa_digit_ram.sv
// ----------------------------------------------------------------------------
// itoa_digit_ram
// Digit buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itoa_digit_ram
   import itoa_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [RADIX_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [RADIX_BITS-1:0] rd_data
);

   logic [RADIX_BITS-1:0] mem [VALUE_BITS];
   logic [RADIX_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/integer_to_ascii_any_base_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_any_base_unit
// Signed integer to lower-case ascii text in any base from 2 to 36.
// ----------------------------------------------------------------------------
//  channel | direction | payload                 | handshake
//  req_    | in        | value, radix            | req_valid / req_stall
//  rsp_    | out       | char_code, last         | rsp_valid / rsp_stall
//
//  each digit takes four 8-bit steps of the shared divider and a hand-off,
//  each character a fetch and a send state through the digit buffer read port.
//  the block takes one request at a time and holds req_stall until the last
//  character is in the output register.
//  reset clears the control state only; the digit buffer needs no clearing.
//  rsp_stall holds the output register and the sequencer waits for it.
// ----------------------------------------------------------------------------
module integer_to_ascii_any_base_unit
   import itoa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_SIGN  = 3'd2;
   localparam logic [2:0] ST_FETCH = 3'd3;
   localparam logic [2:0] ST_SEND  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic                  neg_ff, neg_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [ADDR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  out_free;
   logic                  out_load;
   rsp_payload_type       out_item;
   logic [VALUE_BITS-1:0] raw_value;
   logic [VALUE_BITS-1:0] magnitude;
   logic [RADIX_BITS-1:0] radix_sat;

   div_ctl_type           div_ctl;
   logic [VALUE_BITS-1:0] div_dividend;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [RADIX_BITS-1:0] div_remainder;

   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [RADIX_BITS-1:0] ram_rd_data;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // most negative value comes out right as an unsigned magnitude
   assign raw_value = req_data.value;
   assign magnitude = raw_value[VALUE_BITS-1] ? (~raw_value + 1'b1) : raw_value;

   always_comb begin
      radix_sat = req_data.radix;
      if (req_data.radix < MIN_RADIX) begin
         radix_sat = MIN_RADIX;
      end else if (req_data.radix > MAX_RADIX) begin
         radix_sat = MAX_RADIX;
      end
   end

   always_comb begin
      state_in      = state_ff;
      neg_in        = neg_ff;
      radix_in      = radix_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      div_ctl.start = 1'b0;
      div_ctl.radix = radix_ff;
      div_dividend  = div_quotient;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      out_load      = 1'b0;
      out_item      = '{char_code: MINUS_CODE, last: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               neg_in        = raw_value[VALUE_BITS-1];
               radix_in      = radix_sat;
               count_in      = '0;
               div_ctl.start = 1'b1;
               div_ctl.radix = radix_sat;
               div_dividend  = magnitude;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
               if (div_quotient == '0) begin
                  rd_ptr_in = count_ff[ADDR_BITS-1:0];
                  state_in  = neg_ff ? ST_SIGN : ST_FETCH;
               end else begin
                  div_ctl.start = 1'b1;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            ram_rd_en = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            out_item.char_code = glyph_of(ram_rd_data);
            out_item.last      = (rd_ptr_ff == '0);
            if (out_free) begin
               out_load = 1'b1;
               if (rd_ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_ptr_in = rd_ptr_ff - 1'b1;
                  state_in  = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register keeps the sequencer apart from the consumer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_item;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         neg_ff       <= neg_in;
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      radix_ff    <= radix_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   itoa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   itoa_digit_ram u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_BITS-1:0]),
      .wr_data (div_remainder),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // never more digits than value bits
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(VALUE_BITS))
      else $error("digit count beyond buffer depth");

   // the divider only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider result outside divide phase");

   // the stored base stays saturated while a request is in work
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (radix_ff >= MIN_RADIX && radix_ff <= MAX_RADIX))
      else $error("radix out of range during conversion");

   // a digit is always below the base it was taken in
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (div_remainder < radix_ff))
      else $error("remainder not below radix");

endmodule

>>> bench/integer_to_ascii_any_base_unit_tb.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_any_base_unit_tb
// Checks the signed integer to ascii text converter against a local predictor.
// A table of directed requests covers zero, the extremes, the most negative
// value and out-of-range bases. A random run follows with bursty gaps on both
// channels and one long output hold-off. Every character is compared in order.
// ----------------------------------------------------------------------------
module integer_to_ascii_any_base_unit_tb
   import itoa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_ROWS   = 25;
   localparam int RANDOM_REQUESTS = 205;
   localparam int QUIET_REQUESTS  = 40;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 300;
   localparam int CYCLE_LIMIT     = 800000;
   localparam int REPORT_LIMIT    = 10;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   rsp_payload_type expected_chars[$];
   rsp_payload_type want;
   int              requests_accepted = 0;
   int              mismatch_count    = 0;
   int              cycle_count       = 0;
   bit              quiet_tail        = 1'b0;
   bit              long_hold_done    = 1'b0;

   integer_to_ascii_any_base_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[integer_to_ascii_any_base_unit] ERROR");
         $finish;
      end
   end

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%s", what);
      end
   endtask

   // characters of the value's text, most significant first, minus sign leading
   function automatic void predict_text(input req_payload_type item);
      logic [RADIX_BITS-1:0] base;
      logic [VALUE_BITS-1:0] magnitude;
      logic [RADIX_BITS-1:0] digit;
      rsp_payload_type       text[$];
      rsp_payload_type       ch;
      base = item.radix;
      if (base < MIN_RADIX) begin
         base = MIN_RADIX;
      end else if (base > MAX_RADIX) begin
         base = MAX_RADIX;
      end
      // most negative value wraps to its own unsigned magnitude
      magnitude = item.value[VALUE_BITS-1] ? (~item.value + 1'b1) : item.value;
      do begin
         digit = RADIX_BITS'(magnitude % VALUE_BITS'(base));
         if (digit < DECIMAL_DIGITS) begin
            ch.char_code = ZERO_CODE + CHAR_BITS'(digit);
         end else begin
            ch.char_code = LOWER_A_CODE + CHAR_BITS'(digit - DECIMAL_DIGITS);
         end
         ch.last = (text.size() == 0);
         text.push_front(ch);
         magnitude = magnitude / VALUE_BITS'(base);
      end while (magnitude != 0);
      if (item.value[VALUE_BITS-1]) begin
         ch.char_code = MINUS_CODE;
         ch.last      = 1'b0;
         text.push_front(ch);
      end
      foreach (text[i]) begin
         expected_chars.push_back(text[i]);
      end
   endfunction

   function automatic void expect_typed(input string text);
      rsp_payload_type ch;
      for (int i = 0; i < text.len(); i++) begin
         ch.char_code = CHAR_BITS'(text[i]);
         ch.last      = (i == text.len() - 1);
         expected_chars.push_back(ch);
      end
   endfunction

   // directed table: an empty text means the predictor supplies the answer
   task automatic directed_row(input int row, output req_payload_type item,
                               output string text);
      text = "";
      case (row)
         0:  begin item.value = 0;             item.radix = 10; text = "0";           end
         1:  begin item.value = 0;             item.radix = 2;  text = "0";           end
         2:  begin item.value = 0;             item.radix = 63; text = "0";           end
         3:  begin item.value = 0;             item.radix = 1;  text = "0";           end
         4:  begin item.value = 32'sh7fffffff; item.radix = 16; text = "7fffffff";    end
         5:  begin item.value = 32'sh80000000; item.radix = 16; text = "-80000000";   end
         6:  begin item.value = -1;            item.radix = 10; text = "-1";          end
         7:  begin item.value = 32'sh7fffffff; item.radix = 10; text = "2147483647";  end
         8:  begin item.value = 32'sh80000000; item.radix = 10; text = "-2147483648"; end
         9:  begin item.value = 35;            item.radix = 36; text = "z";           end
         10: begin item.value = 71;            item.radix = 63; text = "1z";          end
         11: begin item.value = 36;            item.radix = 37; text = "10";          end
         12: begin item.value = 123;           item.radix = 0;  text = "1111011";     end
         13: begin item.value = 5;             item.radix = 1;  text = "101";         end
         14: begin item.value = 255;           item.radix = 16; text = "ff";          end
         15: begin item.value = -255;          item.radix = 16; text = "-ff";         end
         16: begin item.value = 10;            item.radix = 11; text = "a";           end
         17: begin item.value = 9;             item.radix = 10; text = "9";           end
         18: begin item.value = 32'sh80000000; item.radix = 2;                        end
         19: begin item.value = 32'sh7fffffff; item.radix = 2;                        end
         20: begin item.value = 32'sh80000000; item.radix = 36;                       end
         21: begin item.value = 32'sh55555555; item.radix = 3;                        end
         22: begin item.value = -12345;        item.radix = 7;                        end
         23: begin item.value = 32'shaaaaaaaa; item.radix = 32;                       end
         default: begin item.value = 1295;     item.radix = 36; text = "zz";          end
      endcase
   endtask

   function automatic logic [RADIX_BITS-1:0] pick_radix();
      if ($urandom_range(0, 9) == 0) begin
         return RADIX_BITS'($urandom_range(0, 63));
      end
      return RADIX_BITS'($urandom_range(2, 36));
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_value(
      input logic [RADIX_BITS-1:0] radix);
      logic [RADIX_BITS-1:0]        base;
      logic [VALUE_BITS-1:0]        power;
      logic signed [VALUE_BITS-1:0] v;
      int                           steps;
      base = (radix < MIN_RADIX) ? MIN_RADIX : (radix > MAX_RADIX) ? MAX_RADIX : radix;
      case ($urandom_range(0, 5))
         1: v = VALUE_BITS'($urandom_range(0, 2000)) - 1000;
         2: begin
            case ($urandom_range(0, 4))
               0: v = 0;
               1: v = 1;
               2: v = -1;
               3: v = 32'sh7fffffff;
               default: v = 32'sh80000000;
            endcase
         end
         3, 4: begin
            // near a power of the base, where the digit count changes
            power = 1;
            steps = $urandom_range(0, 31);
            for (int k = 0; k < steps && power <= 32'h7fffffff / base; k++) begin
               power = power * base;
            end
            v = power - $urandom_range(0, 1);
            if ($urandom_range(0, 1) == 1) begin
               v = -v;
            end
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic offer_request(input req_payload_type item, input string text,
                                input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      requests_accepted++;
      if (text.len() > 0) begin
         expect_typed(text);
      end else begin
         predict_text(item);
      end
   endtask

   // output pacing: short random stalls and one long hold-off that backs up the input
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (!long_hold_done && requests_accepted >= 40) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            hold = 0;
            while (hold < HOLD_CYCLES) begin
               @(posedge clock);
               hold++;
            end
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            note_mismatch($sformatf("unexpected character %h last %b",
                                    rsp_data.char_code, rsp_data.last));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.char_code !== want.char_code || rsp_data.last !== want.last) begin
               note_mismatch($sformatf("char_code exp %h got %h, last exp %b got %b",
                                       want.char_code, rsp_data.char_code,
                                       want.last, rsp_data.last));
            end
         end
      end
   end

   initial begin
      req_payload_type item;
      string           text;
      int              gap;
      do @(posedge clock); while (reset);
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         directed_row(row, item, text);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
         offer_request(item, text, gap);
      end
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n >= RANDOM_REQUESTS - QUIET_REQUESTS) begin
            quiet_tail = 1'b1;
         end
         item.radix = pick_radix();
         item.value = pick_value(item.radix);
         gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
         offer_request(item, "", gap);
      end
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[integer_to_ascii_any_base_unit] OK");
      end else begin
         $display("[integer_to_ascii_any_base_unit] ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/itoa_pkg.sv
hdl/itoa_divider.sv
hdl/itoa_digit_ram.sv
hdl/integer_to_ascii_any_base_unit.sv
bench/integer_to_ascii_any_base_unit_tb.sv
